// ===== design/fid_pkg.sv =====
// Shared types, register indexes and CRC-32 helpers for the fork id checker.
package fid_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   typedef enum logic [1:0] {
      KIND_GENESIS = 2'd0,
      KIND_FORK    = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   localparam logic [1:0] CSR_HEAD_BLOCK  = 2'd0;
   localparam logic [1:0] CSR_REMOTE_HASH = 2'd1;
   localparam logic [1:0] CSR_REMOTE_NEXT = 2'd2;

   typedef struct packed {
      logic [63:0] head_block;
      logic [31:0] remote_hash;
      logic [63:0] remote_next;
   } cfg_type;

   typedef struct packed {
      logic [31:0] fork_hash;
      logic [63:0] fork_next;
      logic        compatible;
   } result_type;

   // Folds one byte into a chained CRC-32 (reflected, inverted on entry and exit).
   function automatic logic [31:0] crc_add_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = ~crc;
      c[7:0] = c[7:0] ^ data;
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return ~c;
   endfunction

   // Folds a 64-bit number in as eight big-endian bytes.
   function automatic logic [31:0] crc_add_u64(input logic [31:0] crc, input logic [63:0] v);
      logic [31:0] c;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         c = crc_add_byte(c, v[8*i +: 8]);
      end
      return c;
   endfunction

endpackage

// ===== design/fid_if.sv =====
// Valid/ready channel interfaces for request and response beats.
interface fid_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

interface fid_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] fork_hash;
   logic [63:0] fork_next;
   logic        compatible;

   modport source (output valid, output fork_hash, output fork_next, output compatible,
                   input ready);
   modport sink (input valid, input fork_hash, input fork_next, input compatible,
                 output ready);
endinterface

// ===== design/fid_core.sv =====
// Chain state and per-beat update: local id, probe chain and verdict.
module fid_core import fid_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [1:0]  kind,
   input  logic [63:0] value,
   input  cfg_type     cfg,
   output logic        emit,
   output result_type  result
);

   logic        in_genesis_ff, in_genesis_in;
   logic [31:0] local_crc_ff, local_crc_in;
   logic [63:0] local_next_ff, local_next_in;
   logic        local_done_ff, local_done_in;
   logic [31:0] probe_crc_ff, probe_crc_in;
   logic        matched_ff, matched_in;
   logic [63:0] common_fork_ff, common_fork_in;
   logic        want_next_ff, want_next_in;
   logic [63:0] probe_next_ff, probe_next_in;
   logic        next_present_ff, next_present_in;

   logic        genesis_match;
   logic        matched_c, want_c;
   logic [63:0] common_c;
   logic [31:0] local_fold, probe_fold;
   logic        before_head, verdict;

   // The genesis match test happens on the first fork or end beat.
   assign genesis_match = in_genesis_ff && (probe_crc_ff == cfg.remote_hash);
   assign matched_c     = matched_ff || genesis_match;
   assign want_c        = genesis_match ? 1'b1 : want_next_ff;
   assign common_c      = genesis_match ? 64'd0 : common_fork_ff;

   assign local_fold = crc_add_u64(local_crc_ff, value);
   assign probe_fold = crc_add_u64(probe_crc_ff, value);

   assign before_head = next_present_ff && (probe_next_ff <= cfg.head_block);
   assign verdict = matched_c &&
                    ((cfg.head_block < common_c) ||
                     (before_head && (cfg.remote_next == probe_next_ff)) ||
                     (!before_head && ((cfg.remote_next == 64'd0) ||
                                       (cfg.remote_next > cfg.head_block))));

   always_comb begin
      in_genesis_in   = in_genesis_ff;
      local_crc_in    = local_crc_ff;
      local_next_in   = local_next_ff;
      local_done_in   = local_done_ff;
      probe_crc_in    = probe_crc_ff;
      matched_in      = matched_ff;
      common_fork_in  = common_fork_ff;
      want_next_in    = want_next_ff;
      probe_next_in   = probe_next_ff;
      next_present_in = next_present_ff;
      emit            = 1'b0;
      result.fork_hash  = local_crc_ff;
      result.fork_next  = local_done_ff ? local_next_ff : 64'd0;
      result.compatible = verdict;
      case (kind)
         KIND_GENESIS: begin
            if (in_genesis_ff) begin
               local_crc_in = crc_add_byte(local_crc_ff, value[7:0]);
               probe_crc_in = crc_add_byte(probe_crc_ff, value[7:0]);
            end
         end
         KIND_FORK: begin
            in_genesis_in  = 1'b0;
            matched_in     = matched_c;
            want_next_in   = want_c;
            common_fork_in = common_c;
            if (!local_done_ff) begin
               if (value > cfg.head_block) begin
                  local_next_in = value;
                  local_done_in = 1'b1;
               end else begin
                  local_crc_in = local_fold;
               end
            end
            if (matched_c) begin
               if (want_c) begin
                  probe_next_in   = value;
                  next_present_in = 1'b1;
                  want_next_in    = 1'b0;
               end
            end else begin
               probe_crc_in = probe_fold;
               if (probe_fold == cfg.remote_hash) begin
                  matched_in     = 1'b1;
                  common_fork_in = value;
                  want_next_in   = 1'b1;
               end
            end
         end
         KIND_END: begin
            emit            = 1'b1;
            in_genesis_in   = 1'b1;
            local_crc_in    = 32'd0;
            local_next_in   = 64'd0;
            local_done_in   = 1'b0;
            probe_crc_in    = 32'd0;
            matched_in      = 1'b0;
            common_fork_in  = 64'd0;
            want_next_in    = 1'b0;
            probe_next_in   = 64'd0;
            next_present_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_genesis_ff   <= 1'b1;
         local_crc_ff    <= 32'd0;
         local_next_ff   <= 64'd0;
         local_done_ff   <= 1'b0;
         probe_crc_ff    <= 32'd0;
         matched_ff      <= 1'b0;
         common_fork_ff  <= 64'd0;
         want_next_ff    <= 1'b0;
         probe_next_ff   <= 64'd0;
         next_present_ff <= 1'b0;
      end else if (step) begin
         in_genesis_ff   <= in_genesis_in;
         local_crc_ff    <= local_crc_in;
         local_next_ff   <= local_next_in;
         local_done_ff   <= local_done_in;
         probe_crc_ff    <= probe_crc_in;
         matched_ff      <= matched_in;
         common_fork_ff  <= common_fork_in;
         want_next_ff    <= want_next_in;
         probe_next_ff   <= probe_next_in;
         next_present_ff <= next_present_in;
      end
   end

endmodule

// ===== design/fork_id_crc_chain_check.sv =====
// An accepted beat is held in the input register and updates the chain state from
// there; an end beat also loads its response beat into the response register.
// Throughput: one request beat per cycle unless an end beat waits for a full response
// register; the 64-bit CRC fold is a single XOR tree.
// Reset is synchronous and active high: it clears the chain state, the pipeline
// valids and the three control registers (head block, remote hash, remote next).
module fork_id_crc_chain_check import fid_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   fid_req_if.sink     req_chan,
   fid_rsp_if.source   rsp_chan
);

   // Control registers. The user must write them only while the block is idle; the block does not enforce this.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEAD_BLOCK:  cfg_ff.head_block  <= csr_wdata;
            CSR_REMOTE_HASH: cfg_ff.remote_hash <= csr_wdata[31:0];
            CSR_REMOTE_NEXT: cfg_ff.remote_next <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input register: holds the accepted request beat while the chain update works on it.
   logic        s1_valid_ff;
   logic [1:0]  s1_kind_ff;
   logic [63:0] s1_value_ff;

   // Response register: parts the response side from the chain update.
   logic        rsp_valid_ff;
   result_type  rsp_data_ff;

   logic        out_free;
   logic        advance;
   logic        step;
   logic        emit;
   result_type  result;

   // Only an end beat needs room in the response register; every other beat
   // moves on at once, so the input register never stalls on those.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = !s1_valid_ff || (s1_kind_ff != KIND_END) || out_free;
   assign step     = s1_valid_ff && advance;

   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_chan.valid) begin
         s1_kind_ff  <= req_chan.kind;
         s1_value_ff <= req_chan.value;
      end
   end

   fid_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .kind   (s1_kind_ff),
      .value  (s1_value_ff),
      .cfg    (cfg_ff),
      .emit   (emit),
      .result (result)
   );

   // A response beat is loaded when an end beat is processed and holds until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.fork_hash  = rsp_data_ff.fork_hash;
   assign rsp_chan.fork_next  = rsp_data_ff.fork_next;
   assign rsp_chan.compatible = rsp_data_ff.compatible;

endmodule

// ===== design/fid_checker.sv =====
// Port-level checks for the fork id checker, bound to the top level.
module fid_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_fork_hash,
   input logic        rsp_compatible
);

   // The request side only stalls when a response beat is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a waiting response");

   // No response beat is left over from before reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_fork_hash) && $stable(rsp_compatible)))
      else $error("response payload changed while stalled");

endmodule

bind fork_id_crc_chain_check fid_checker u_fid_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_fork_hash  (rsp_chan.fork_hash),
   .rsp_compatible (rsp_chan.compatible)
);

// ===== tb/sv/fork_id_crc_chain_check_test.sv =====
// Self-checking testbench for the fork id checker: directed lists, then random fork lists.
`timescale 1ns / 1ps

module fork_id_crc_chain_check_test import fid_pkg::*; ();

   // Reflected IEEE CRC-32 polynomial, used by the local fork id model below.
   localparam logic [31:0] CRC32_REFLECTED = 32'hEDB8_8320;
   localparam logic [63:0] ALL_ONES_64     = 64'hFFFF_FFFF_FFFF_FFFF;
   // The kind code that the block has no use for; such beats must be dropped.
   localparam logic [1:0]  KIND_SPARE      = 2'd3;
   localparam int          BEAT_GOAL       = 1150;
   localparam int          ID_GOAL         = 48;
   // Extra edges that settle waits once every owed fork id has come back, for margin.
   localparam int          DRAIN_CYCLES    = 4;
   localparam int          TIMEOUT_NS      = 5_000_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   fid_req_if req_bus ();
   fid_rsp_if rsp_bus ();

   fork_id_crc_chain_check uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Local copy of the chain state. "own" fields follow the local fork id, "probe"
   // fields follow the search for the remote hash, "follow" is the fork after the match.
   typedef struct {
      bit          in_genesis;
      logic [31:0] own_crc;
      logic [63:0] own_next;
      bit          own_stopped;
      logic [31:0] probe_crc;
      bit          found;
      logic [63:0] common_blk;
      bit          need_follow;
      logic [63:0] follow_blk;
      bit          follow_seen;
   } chain_state_type;

   chain_state_type chain;

   // Mirror of the three control registers.
   logic [63:0] head_cfg;
   logic [31:0] remote_hash_cfg;
   logic [63:0] remote_next_cfg;

   // Fork ids still owed by the block, oldest first.
   result_type awaited_ids[$];

   // The list under test: genesis hash bytes and fork block numbers.
   logic [7:0]  plan_gen[$];
   logic [63:0] plan_forks[$];

   int beats_counted;
   int ids_checked;
   int mismatch_count;
   bit sender_lazy;
   bit receiver_lazy;

   // ------------------------------------------------------------------
   // Fork id model
   // ------------------------------------------------------------------

   // One byte into the chained CRC, serial form: feedback is the low bit of the
   // register against the next data bit, least significant bit first.
   function automatic logic [31:0] crc32_octet(input logic [31:0] crc, input logic [7:0] octet);
      logic [31:0] r;
      bit          feedback;
      r = ~crc;
      for (int i = 0; i < 8; i++) begin
         feedback = r[0] ^ octet[i];
         r = r >> 1;
         if (feedback) r = r ^ CRC32_REFLECTED;
      end
      return ~r;
   endfunction

   // A block number goes in as eight bytes, most significant first.
   function automatic logic [31:0] crc32_u64_be(input logic [31:0] crc, input logic [63:0] blk);
      logic [31:0] r;
      r = crc;
      for (int k = 0; k < 8; k++) r = crc32_octet(r, blk[63 - 8*k -: 8]);
      return r;
   endfunction

   function automatic void clear_chain();
      chain = '{default: 0};
      chain.in_genesis = 1'b1;
   endfunction

   // The genesis match test happens once, on the first beat that ends the genesis bytes.
   function automatic void seal_genesis();
      if (chain.in_genesis) begin
         chain.in_genesis = 1'b0;
         if (chain.probe_crc == remote_hash_cfg) begin
            chain.found       = 1'b1;
            chain.common_blk  = '0;
            chain.need_follow = 1'b1;
         end
      end
   endfunction

   // Applies one accepted beat; returns 1 when the beat owes a response.
   function automatic bit advance_chain(input logic [1:0] kind, input logic [63:0] value,
                                        output result_type id_word);
      bit behind_head;
      bit ok;
      id_word = '0;
      case (kind)
         KIND_GENESIS: begin
            // Genesis bytes after the first fork are dropped.
            if (chain.in_genesis) begin
               chain.own_crc   = crc32_octet(chain.own_crc, value[7:0]);
               chain.probe_crc = crc32_octet(chain.probe_crc, value[7:0]);
            end
         end
         KIND_FORK: begin
            seal_genesis();
            if (!chain.own_stopped) begin
               if (value > head_cfg) begin
                  chain.own_next    = value;
                  chain.own_stopped = 1'b1;
               end else begin
                  chain.own_crc = crc32_u64_be(chain.own_crc, value);
               end
            end
            if (chain.found) begin
               if (chain.need_follow) begin
                  chain.follow_blk  = value;
                  chain.follow_seen = 1'b1;
                  chain.need_follow = 1'b0;
               end
            end else begin
               chain.probe_crc = crc32_u64_be(chain.probe_crc, value);
               if (chain.probe_crc == remote_hash_cfg) begin
                  chain.found       = 1'b1;
                  chain.common_blk  = value;
                  chain.need_follow = 1'b1;
               end
            end
         end
         KIND_END: begin
            seal_genesis();
            ok = 1'b0;
            if (chain.found) begin
               behind_head = chain.follow_seen && (chain.follow_blk <= head_cfg);
               ok = (head_cfg < chain.common_blk) ||
                    (behind_head && remote_next_cfg == chain.follow_blk) ||
                    (!behind_head && (remote_next_cfg == '0 || remote_next_cfg > head_cfg));
            end
            id_word.fork_hash  = chain.own_crc;
            id_word.fork_next  = chain.own_stopped ? chain.own_next : '0;
            id_word.compatible = ok;
            clear_chain();
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Remote hash that a peer would announce after the genesis and the first forks_folded forks.
   function automatic logic [31:0] chain_hash(input int forks_folded);
      logic [31:0] h;
      h = '0;
      foreach (plan_gen[i]) h = crc32_octet(h, plan_gen[i]);
      for (int i = 0; i < forks_folded; i++) h = crc32_u64_be(h, plan_forks[i]);
      return h;
   endfunction

   // ------------------------------------------------------------------
   // Helpers shared by the tests
   // ------------------------------------------------------------------

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [63:0] pick_fork();
      if (plan_forks.size() == 0) return rand64();
      return plan_forks[$urandom_range(0, plan_forks.size() - 1)];
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("ERROR at %0t: %s: got %h, want %h", $time, what, got, want);
   endtask

   // Sends one request beat. Called on a rising edge; returns on the edge that
   // accepted the beat with valid still high, so a following beat may go out at once.
   task automatic send_beat(input logic [1:0] kind, input logic [63:0] value);
      int         gap;
      result_type id_word;
      gap = (sender_lazy && $urandom_range(0, 99) < 40) ? gap_length() : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      if (kind == KIND_FORK || kind == KIND_END || (kind == KIND_GENESIS && chain.in_genesis))
         beats_counted++;
      if (advance_chain(kind, value, id_word)) awaited_ids.push_back(id_word);
   endtask

   // Holds the sender until every owed fork id has come back and the block has drained.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (awaited_ids.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers back to back; only called after settle.
   task automatic apply_settings(input logic [63:0] head, input logic [31:0] rhash,
                                 input logic [63:0] rnext);
      csr_we    <= 1'b1;
      csr_index <= CSR_HEAD_BLOCK;
      csr_wdata <= head;
      @(posedge clock);
      csr_index <= CSR_REMOTE_HASH;
      // Upper bits are junk on purpose: the hash register keeps only 32 bits.
      csr_wdata <= {$urandom, rhash};
      @(posedge clock);
      csr_index <= CSR_REMOTE_NEXT;
      csr_wdata <= rnext;
      @(posedge clock);
      csr_we <= 1'b0;
      head_cfg        = head;
      remote_hash_cfg = rhash;
      remote_next_cfg = rnext;
   endtask

   // A beat the block must drop: the spare kind code, or a late genesis byte.
   task automatic inject_noise(input bit allow_genesis);
      if ($urandom_range(0, 9) == 0) begin
         if (allow_genesis && $urandom_range(0, 1) == 1) send_beat(KIND_GENESIS, rand64());
         else send_beat(KIND_SPARE, rand64());
      end
   endtask

   // Sends the planned list; genesis bytes carry random upper bits, which must not matter.
   task automatic run_chain(input bit noisy, input bit close_list);
      logic [63:0] v;
      foreach (plan_gen[i]) begin
         if (noisy) inject_noise(1'b0);
         v = rand64();
         v[7:0] = plan_gen[i];
         send_beat(KIND_GENESIS, v);
      end
      foreach (plan_forks[i]) begin
         if (noisy) inject_noise(i > 0);
         send_beat(KIND_FORK, plan_forks[i]);
      end
      if (noisy) inject_noise(plan_forks.size() > 0);
      if (close_list) send_beat(KIND_END, rand64());
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // An end beat alone. With reset registers the empty CRC (zero) equals the remote
   // hash, so the genesis match is taken and the verdict is compatible. Then the
   // registers go to their top values and the same list must be rejected.
   task automatic test_empty_list();
      send_beat(KIND_END, rand64());
      settle();
      apply_settings(ALL_ONES_64, 32'hFFFF_FFFF, ALL_ONES_64);
      send_beat(KIND_END, '0);
   endtask

   // Remote hash at genesis, remote next equal to the fork that follows: compatible.
   // Then a match after the last fork with a remote next the head has already passed
   // and no fork there: incompatible.
   task automatic test_genesis_match();
      plan_gen   = '{8'h00, 8'hFF};
      plan_forks = '{64'd3, 64'd9};
      settle();
      apply_settings(64'd5, chain_hash(0), 64'd3);
      run_chain(1'b0, 1'b1);
      settle();
      apply_settings(64'd20, chain_hash(2), 64'd15);
      run_chain(1'b0, 1'b1);
   endtask

   // Block numbers at both extremes. The remote hash sits after the top fork, which
   // lies above the head, so the remote peer is simply ahead. A spare-kind beat and a
   // late genesis byte are mixed in and must change nothing.
   task automatic test_fork_above_head();
      logic [63:0] v;
      plan_gen   = '{8'h5A};
      plan_forks = '{64'd0, ALL_ONES_64};
      settle();
      apply_settings('0, chain_hash(2), '0);
      v = rand64();
      v[7:0] = 8'h5A;
      send_beat(KIND_GENESIS, v);
      send_beat(KIND_FORK, '0);
      send_beat(KIND_SPARE, ALL_ONES_64);
      send_beat(KIND_FORK, ALL_ONES_64);
      send_beat(KIND_GENESIS, ALL_ONES_64);
      send_beat(KIND_END, ALL_ONES_64);
   endtask

   // Forks in a descending step are folded in arrival order without any check.
   task automatic test_forks_out_of_order();
      plan_gen   = '{8'h01};
      plan_forks = '{64'd10, 64'd4, 64'd7};
      settle();
      apply_settings(64'd5, chain_hash(3), rand64());
      run_chain(1'b0, 1'b1);
   endtask

   // Random lists, mostly well formed. The remote hash is usually taken from a point
   // on the list so that matches are common; the head and the remote next are set
   // around the fork numbers so that every branch of the verdict is reached.
   task automatic test_random_chains();
      int          n_gen;
      int          n_forks;
      int          mode;
      int          j;
      int          r;
      int          a;
      int          b;
      int          reps;
      bit          broken;
      logic [63:0] acc;
      logic [63:0] head;
      logic [63:0] follow;
      logic [63:0] rnext;
      logic [63:0] tmp;
      logic [31:0] rhash;
      while (beats_counted < BEAT_GOAL || ids_checked < ID_GOAL) begin
         plan_gen.delete();
         plan_forks.delete();
         r = $urandom_range(0, 99);
         n_gen = (r < 35) ? 32 : (r < 42) ? 0 : $urandom_range(1, 12);
         n_forks = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 6) : $urandom_range(7, 14);
         repeat (n_gen) plan_gen.push_back(8'($urandom_range(0, 255)));
         mode = $urandom_range(0, 3);
         // Wide steps cover the upper bits; near-top lists sit just under the maximum.
         acc = (mode == 1) ? 64'hFFFF_FFFF_FFFF_0000 + 64'($urandom_range(0, 3000))
                           : 64'($urandom_range(0, 3000));
         repeat (n_forks) begin
            if (mode == 0) acc = acc + {$urandom_range(0, 32'h0800_0000), $urandom};
            else acc = acc + 64'($urandom_range(1, 4000));
            plan_forks.push_back(acc);
         end
         if ($urandom_range(0, 9) == 0) plan_forks.push_front('0);
         if ($urandom_range(0, 9) == 0) plan_forks.push_back(ALL_ONES_64);
         n_forks = plan_forks.size();

         case ($urandom_range(0, 9))
            0:       head = '0;
            1:       head = ALL_ONES_64;
            2, 3:    head = pick_fork();
            4:       head = pick_fork() - 64'd1;
            5:       head = pick_fork() + 64'd1;
            6:       head = 64'($urandom_range(0, 20000));
            default: head = rand64();
         endcase

         j = $urandom_range(0, n_forks);
         follow = (j < n_forks) ? plan_forks[j] : '0;
         r = $urandom_range(0, 99);
         if (r < 65)      rhash = chain_hash(j);
         else if (r < 72) rhash = '0;
         else if (r < 79) rhash = 32'hFFFF_FFFF;
         else             rhash = $urandom;

         case ($urandom_range(0, 9))
            0:       rnext = '0;
            1, 2, 3: rnext = follow;
            4:       rnext = ALL_ONES_64;
            5:       rnext = head;
            6:       rnext = head + 64'd1;
            7:       rnext = pick_fork();
            8:       rnext = head - 64'd1;
            default: rnext = rand64();
         endcase

         settle();
         apply_settings(head, rhash, rnext);

         // The same list goes out up to three times with no pause between lists.
         reps = $urandom_range(1, 3);
         repeat (reps) begin
            sender_lazy   = ($urandom_range(0, 3) != 0);
            receiver_lazy = ($urandom_range(0, 3) != 0);
            broken = ($urandom_range(0, 99) < 8);
            if (broken && n_forks > 1) begin
               a = $urandom_range(0, n_forks - 1);
               b = $urandom_range(0, n_forks - 1);
               tmp = plan_forks[a];
               plan_forks[a] = plan_forks[b];
               plan_forks[b] = tmp;
            end
            // A broken list sometimes loses its end beat and runs into the next list.
            run_chain($urandom_range(0, 3) == 0, !(broken && $urandom_range(0, 1) == 1));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: random back-pressure and the comparison against the model.
   // ------------------------------------------------------------------
   initial begin : response_monitor
      result_type want;
      int         stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_ids.size() == 0) begin
               report_mismatch("response beat with no end beat pending",
                               {32'h0, rsp_bus.fork_hash}, '0);
            end else begin
               want = awaited_ids.pop_front();
               ids_checked++;
               if (rsp_bus.fork_hash !== want.fork_hash)
                  report_mismatch("fork_hash", {32'h0, rsp_bus.fork_hash},
                                  {32'h0, want.fork_hash});
               if (rsp_bus.fork_next !== want.fork_next)
                  report_mismatch("fork_next", rsp_bus.fork_next, want.fork_next);
               if (rsp_bus.compatible !== want.compatible)
                  report_mismatch("compatible", {63'h0, rsp_bus.compatible},
                                  {63'h0, want.compatible});
            end
         end
         if (stall_left == 0 && receiver_lazy && $urandom_range(0, 99) < 25)
            stall_left = gap_length();
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int wait_cycles;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_HEAD_BLOCK;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.kind    = KIND_GENESIS;
      req_bus.value   = '0;
      head_cfg        = '0;
      remote_hash_cfg = '0;
      remote_next_cfg = '0;
      beats_counted   = 0;
      ids_checked     = 0;
      mismatch_count  = 0;
      sender_lazy     = 1'b1;
      receiver_lazy   = 1'b1;
      clear_chain();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_genesis_match();
      test_fork_above_head();
      test_forks_out_of_order();
      test_random_chains();

      // Drain: every owed fork id should arrive well within this bound.
      req_bus.valid <= 1'b0;
      wait_cycles = 0;
      while (awaited_ids.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (awaited_ids.size() != 0)
         report_mismatch("end beats with no response", '0, 64'(awaited_ids.size()));

      if (mismatch_count == 0) begin
         $display("fork_id_crc_chain_check_test OK");
      end else begin
         $display("fork_id_crc_chain_check_test NOT OK");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(TIMEOUT_NS);
      $display("fork_id_crc_chain_check_test NOT OK");
      $finish;
   end

endmodule
